FILE: rtl/lcdfe_pkg.sv
package lcdfe_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 128;
	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 32;

	localparam logic [7:0] HDR_0 = 8'h5A;
	localparam logic [7:0] HDR_1 = 8'hA5;
	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [15:0] CRC_INIT = 16'h0000;
	localparam logic [7:0] LEN_VAR_READ = 8'd4;
	localparam logic [7:0] LEN_REG_READ = 8'd3;
	localparam logic [7:0] LEN_VAR_OVH = 8'd3;
	localparam logic [7:0] LEN_SHORT_OVH = 8'd2;

	localparam logic RST_CRC_EN = 1'b1;
	localparam logic [7:0] RST_VAR_WRITE = 8'd130;
	localparam logic [7:0] RST_VAR_READ = 8'd131;
	localparam logic [7:0] RST_SHORT_WRITE = 8'd130;
	localparam logic [7:0] RST_REG_READ = 8'd129;

	typedef enum logic [1:0] {
		OP_VAR_WRITE   = 2'd0,
		OP_VAR_READ    = 2'd1,
		OP_SHORT_WRITE = 2'd2,
		OP_REG_READ    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_CRC_EN      = 3'd0,
		REG_VAR_WRITE   = 3'd1,
		REG_VAR_READ    = 3'd2,
		REG_SHORT_WRITE = 3'd3,
		REG_REG_READ    = 3'd4
	} reg_idx_t;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_H0   = 11'b000_0000_0010,
		ST_H1   = 11'b000_0000_0100,
		ST_LEN  = 11'b000_0000_1000,
		ST_OPC  = 11'b000_0001_0000,
		ST_AHI  = 11'b000_0010_0000,
		ST_ALO  = 11'b000_0100_0000,
		ST_RCNT = 11'b000_1000_0000,
		ST_DATA = 11'b001_0000_0000,
		ST_CLO  = 11'b010_0000_0000,
		ST_CHI  = 11'b100_0000_0000
	} step_t;

	typedef struct packed {
		logic       crc_enable;
		logic [7:0] var_write_code;
		logic [7:0] var_read_code;
		logic [7:0] short_write_code;
		logic [7:0] reg_read_code;
	} cfg_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/lcdfe_in_if.sv
interface lcdfe_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] address;
	logic [7:0]  payload_length;
	logic [7:0]  read_count;
	logic [7:0]  data_byte;
	logic        first;
	logic        last;

	modport source (
		output valid, op, address, payload_length, read_count, data_byte, first, last,
		input  ready
	);
	modport sink (
		input  valid, op, address, payload_length, read_count, data_byte, first, last,
		output ready
	);
endinterface

FILE: rtl/lcdfe_out_if.sv
interface lcdfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;

	modport source (
		output valid, out_byte, frame_end,
		input  ready
	);
	modport sink (
		input  valid, out_byte, frame_end,
		output ready
	);
endinterface

FILE: rtl/lcdfe_regs.sv
module lcdfe_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lcdfe_pkg::APB_AW-1:0]     paddr,
	input  logic [lcdfe_pkg::APB_DW-1:0]     pwdata,
	output logic [lcdfe_pkg::APB_DW-1:0]     prdata,
	output lcdfe_pkg::cfg_t                  cfg
);

	lcdfe_pkg::cfg_t cfg_q;
	lcdfe_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx = lcdfe_pkg::reg_idx_t'(paddr[lcdfe_pkg::APB_AW-1:2]);
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_enable <= lcdfe_pkg::RST_CRC_EN;
			cfg_q.var_write_code <= lcdfe_pkg::RST_VAR_WRITE;
			cfg_q.var_read_code <= lcdfe_pkg::RST_VAR_READ;
			cfg_q.short_write_code <= lcdfe_pkg::RST_SHORT_WRITE;
			cfg_q.reg_read_code <= lcdfe_pkg::RST_REG_READ;
		end else if (wr_en) begin
			case (idx)
				lcdfe_pkg::REG_CRC_EN: cfg_q.crc_enable <= pwdata[0];
				lcdfe_pkg::REG_VAR_WRITE: cfg_q.var_write_code <= pwdata[7:0];
				lcdfe_pkg::REG_VAR_READ: cfg_q.var_read_code <= pwdata[7:0];
				lcdfe_pkg::REG_SHORT_WRITE: cfg_q.short_write_code <= pwdata[7:0];
				lcdfe_pkg::REG_REG_READ: cfg_q.reg_read_code <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			lcdfe_pkg::REG_CRC_EN: prdata[0] = cfg_q.crc_enable;
			lcdfe_pkg::REG_VAR_WRITE: prdata[7:0] = cfg_q.var_write_code;
			lcdfe_pkg::REG_VAR_READ: prdata[7:0] = cfg_q.var_read_code;
			lcdfe_pkg::REG_SHORT_WRITE: prdata[7:0] = cfg_q.short_write_code;
			lcdfe_pkg::REG_REG_READ: prdata[7:0] = cfg_q.reg_read_code;
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/lcd_command_frame_encoder.sv
// Serial command frame encoder. Each accepted command item turns into one or more
// output bytes, one per cycle unless the output stalls: a frame opener yields 5A A5,
// length, opcode, address, read count or first data byte, CRC low/high if enabled;
// a payload item in an open frame yields its byte, then CRC low/high if it closes
// the frame with a CRC. The next item is taken in the same cycle the last byte of the
// current one enters the output register, so payload bytes also stream at one per
// cycle. A byte step sequencer and a one-byte-per-cycle CRC-16 (poly 8005, init 0)
// set this rate. An item with first low outside a frame is taken and yields nothing.
module lcd_command_frame_encoder #(
	parameter int unsigned MAX_PAYLOAD = lcdfe_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lcdfe_in_if.sink                     cmd,
	lcdfe_out_if.source                  tx,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lcdfe_pkg::APB_AW-1:0] paddr,
	input  logic [lcdfe_pkg::APB_DW-1:0] pwdata,
	output logic [lcdfe_pkg::APB_DW-1:0] prdata,
	output logic                         pready
);

	localparam logic [7:0] MaxPay = 8'(MAX_PAYLOAD);

	lcdfe_pkg::cfg_t cfg;

	lcdfe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// item registers
	lcdfe_pkg::op_t op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  len_s1;
	logic [7:0]  rcnt_s1;
	logic [7:0]  data_s1;
	logic        has_data_s1;
	logic        closes_s1;

	lcdfe_pkg::step_t step_q, step_nxt, step_start;
	logic        in_frame_q;
	logic [15:0] crc_q;
	logic        out_v_q;
	logic [7:0]  out_byte_q;
	logic        out_end_q;

	logic        busy, advance, item_done, accept;
	logic        has_crc;
	logic [7:0]  cur_byte;
	logic [7:0]  plen_sat;
	logic [7:0]  len_in;
	logic        is_read_in;

	assign busy = (step_q != lcdfe_pkg::ST_IDLE);
	assign advance = busy & (~out_v_q | tx.ready);
	assign item_done = advance & (step_nxt == lcdfe_pkg::ST_IDLE);
	assign cmd.ready = ~busy | item_done;
	assign accept = cmd.valid & cmd.ready;
	assign has_crc = closes_s1 & cfg.crc_enable;

	assign is_read_in = cmd.op[0];
	assign plen_sat = (cmd.payload_length > MaxPay) ? MaxPay : cmd.payload_length;

	always_comb begin
		case (lcdfe_pkg::op_t'(cmd.op))
			lcdfe_pkg::OP_VAR_WRITE: len_in = plen_sat + lcdfe_pkg::LEN_VAR_OVH;
			lcdfe_pkg::OP_VAR_READ: len_in = lcdfe_pkg::LEN_VAR_READ;
			lcdfe_pkg::OP_SHORT_WRITE: len_in = plen_sat + lcdfe_pkg::LEN_SHORT_OVH;
			lcdfe_pkg::OP_REG_READ: len_in = lcdfe_pkg::LEN_REG_READ;
			default: len_in = lcdfe_pkg::LEN_REG_READ;
		endcase
	end

	always_comb begin
		if (cmd.first) begin
			step_start = lcdfe_pkg::ST_H0;
		end else if (in_frame_q) begin
			step_start = lcdfe_pkg::ST_DATA;
		end else begin
			step_start = lcdfe_pkg::ST_IDLE;
		end
	end

	always_comb begin
		case (step_q)
			lcdfe_pkg::ST_H0: step_nxt = lcdfe_pkg::ST_H1;
			lcdfe_pkg::ST_H1: step_nxt = lcdfe_pkg::ST_LEN;
			lcdfe_pkg::ST_LEN: step_nxt = lcdfe_pkg::ST_OPC;
			lcdfe_pkg::ST_OPC: step_nxt = op_s1[1] ? lcdfe_pkg::ST_ALO : lcdfe_pkg::ST_AHI;
			lcdfe_pkg::ST_AHI: step_nxt = lcdfe_pkg::ST_ALO;
			lcdfe_pkg::ST_ALO: begin
				if (op_s1[0]) begin
					step_nxt = lcdfe_pkg::ST_RCNT;
				end else if (has_data_s1) begin
					step_nxt = lcdfe_pkg::ST_DATA;
				end else if (has_crc) begin
					step_nxt = lcdfe_pkg::ST_CLO;
				end else begin
					step_nxt = lcdfe_pkg::ST_IDLE;
				end
			end
			lcdfe_pkg::ST_RCNT,
			lcdfe_pkg::ST_DATA: step_nxt = has_crc ? lcdfe_pkg::ST_CLO : lcdfe_pkg::ST_IDLE;
			lcdfe_pkg::ST_CLO: step_nxt = lcdfe_pkg::ST_CHI;
			default: step_nxt = lcdfe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		case (step_q)
			lcdfe_pkg::ST_H0: cur_byte = lcdfe_pkg::HDR_0;
			lcdfe_pkg::ST_H1: cur_byte = lcdfe_pkg::HDR_1;
			lcdfe_pkg::ST_LEN: cur_byte = len_s1;
			lcdfe_pkg::ST_OPC: begin
				case (op_s1)
					lcdfe_pkg::OP_VAR_WRITE: cur_byte = cfg.var_write_code;
					lcdfe_pkg::OP_VAR_READ: cur_byte = cfg.var_read_code;
					lcdfe_pkg::OP_SHORT_WRITE: cur_byte = cfg.short_write_code;
					default: cur_byte = cfg.reg_read_code;
				endcase
			end
			lcdfe_pkg::ST_AHI: cur_byte = addr_s1[15:8];
			lcdfe_pkg::ST_ALO: cur_byte = addr_s1[7:0];
			lcdfe_pkg::ST_RCNT: cur_byte = rcnt_s1;
			lcdfe_pkg::ST_DATA: cur_byte = data_s1;
			lcdfe_pkg::ST_CLO: cur_byte = crc_q[7:0];
			lcdfe_pkg::ST_CHI: cur_byte = crc_q[15:8];
			default: cur_byte = '0;
		endcase
	end

	// capture item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= lcdfe_pkg::op_t'(cmd.op);
			addr_s1 <= cmd.address;
			len_s1 <= len_in;
			rcnt_s1 <= cmd.read_count;
			data_s1 <= cmd.data_byte;
			has_data_s1 <= ~cmd.first | (cmd.payload_length != 8'd0);
			closes_s1 <= cmd.first ? (is_read_in | cmd.last) : cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lcdfe_pkg::ST_IDLE;
			in_frame_q <= 1'b0;
			crc_q <= lcdfe_pkg::CRC_INIT;
			out_v_q <= 1'b0;
			out_byte_q <= '0;
			out_end_q <= 1'b0;
		end else begin
			if (accept) begin
				step_q <= step_start;
			end else if (advance) begin
				step_q <= step_nxt;
			end

			if (accept) begin
				if (cmd.first) begin
					in_frame_q <= ~is_read_in & ~cmd.last;
				end else if (cmd.last) begin
					in_frame_q <= 1'b0;
				end
			end

			if (advance) begin
				case (step_q)
					lcdfe_pkg::ST_H0: crc_q <= lcdfe_pkg::CRC_INIT;
					lcdfe_pkg::ST_OPC,
					lcdfe_pkg::ST_AHI,
					lcdfe_pkg::ST_ALO,
					lcdfe_pkg::ST_RCNT,
					lcdfe_pkg::ST_DATA: crc_q <= lcdfe_pkg::crc_byte(crc_q, cur_byte);
					default: ;
				endcase
			end

			if (advance) begin
				out_v_q <= 1'b1;
				out_byte_q <= cur_byte;
				out_end_q <= (step_nxt == lcdfe_pkg::ST_IDLE) & closes_s1;
			end else if (tx.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign tx.valid = out_v_q;
	assign tx.out_byte = out_byte_q;
	assign tx.frame_end = out_end_q;

endmodule

FILE: rtl/lcdfe_checker.sv
module lcdfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       cmd_first,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] tx_out_byte,
	input logic       tx_frame_end
);

	// hold a stalled output byte
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid & ~tx_ready |=> tx_valid & $stable(tx_out_byte) & $stable(tx_frame_end))
		else $error("stalled output byte changed");

	// no new item is taken while a frame opener sends its header
	a_hdr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid & cmd_ready & cmd_first |=> ~cmd_ready)
		else $error("next item taken during header");

	// the output is valid after a frame opener is taken, with 5A or a stalled earlier byte
	a_hdr_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid & cmd_ready & cmd_first |=> ##1 tx_valid)
		else $error("no output after frame opener");

endmodule

bind lcd_command_frame_encoder lcdfe_checker u_lcdfe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.cmd_first    (cmd.first),
	.tx_valid     (tx.valid),
	.tx_ready     (tx.ready),
	.tx_out_byte  (tx.out_byte),
	.tx_frame_end (tx.frame_end)
);
